/* rtl/mbc1_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbc1_pkg
// Types and constants shared by the bank controller front end, queue and
// back end.
// ----------------------------------------------------------------------------
package mbc1_pkg;

  localparam int unsigned ROM_ADDR_W    = 21;
  localparam int unsigned RAM_IDX_W     = 15;
  localparam int unsigned RAM_BANK_SIZE = 32'h2000;

  // Access kind carried on the input tuser.
  localparam logic CMD_READ  = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  // Bits [15:13] of the address that mark the RAM window.
  localparam logic [2:0] RAM_WINDOW_TAG = 3'b101;

  // Bits [14:13] of a control write below the RAM window.
  localparam logic [1:0] REG_SEL_ENABLE = 2'd0;
  localparam logic [1:0] REG_SEL_LOW    = 2'd1;
  localparam logic [1:0] REG_SEL_HIGH   = 2'd2;
  localparam logic [1:0] REG_SEL_MODE   = 2'd3;

  typedef enum logic [2:0] {
    OP_ROM_READ,
    OP_RAM_READ,
    OP_RAM_WRITE,
    OP_REG_WRITE,
    OP_ILLEGAL
  } op_kind_t;

  typedef enum logic [1:0] {
    OUT_ROM_READ  = 2'd0,
    OUT_RAM_READ  = 2'd1,
    OUT_WRITE     = 2'd2,
    OUT_ILLEGAL   = 2'd3
  } outcome_t;

  typedef struct packed {
    op_kind_t                kind;
    logic [ROM_ADDR_W-1:0]   rom_address;
    logic [RAM_IDX_W-1:0]    ram_index;
    logic [7:0]              write_data;
  } op_t;

endpackage
`default_nettype wire

/* rtl/mbc1_bank_mapper_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbc1_bank_mapper_core
// Cartridge bank controller: maps bus accesses to ROM addresses, keeps the
// bank registers and holds the banked cartridge RAM.
// ----------------------------------------------------------------------------
// One access word is taken per clock while the RAM clear and a full queue
// do not hold the input, and one result word comes out for each. An access
// passes the queue register and then the output register before its result
// word is valid, and a stall on the output can hold it in either. The single
// RAM port, read and written once per cycle, sets that rate. The front end
// decodes the address and updates the bank registers as the word is
// accepted, a two-entry queue decouples it from the back end, and the back
// end does the RAM access and drives a registered result. After reset the
// RAM is cleared one byte per cycle, so s_tready stays low until the clear ends.
module mbc1_bank_mapper_core import mbc1_pkg::*; #(
  parameter int unsigned RAM_DEPTH = 32768
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // bus_address[15:0], write_data[23:16]
  input  wire logic        s_tuser,   // cmd
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // rom_address[20:0], read_data[28:21], zero
  output logic [1:0]       m_tuser    // outcome
);

  logic clearing;
  logic fe_valid;
  logic fe_ready;
  op_t  fe_op;
  logic be_valid;
  logic be_ready;
  op_t  be_op;

  mbc1_front #(
    .RAM_DEPTH(RAM_DEPTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .clearing (clearing),
    .op_valid (fe_valid),
    .op_ready (fe_ready),
    .op       (fe_op)
  );

  mbc1_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fe_valid),
    .in_ready  (fe_ready),
    .in_op     (fe_op),
    .out_valid (be_valid),
    .out_ready (be_ready),
    .out_op    (be_op)
  );

  mbc1_back #(
    .RAM_DEPTH(RAM_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .clearing (clearing),
    .op_valid (be_valid),
    .op_ready (be_ready),
    .op       (be_op),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
`default_nettype wire

/* rtl/mbc1_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbc1_front
// Accepts bus accesses, decodes the address window, keeps the bank and mode
// registers and hands a classified operation to the queue.
// ----------------------------------------------------------------------------
module mbc1_front import mbc1_pkg::*; #(
  parameter int unsigned RAM_DEPTH = 32768
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // bus_address[15:0], write_data[23:16]
  input  wire logic        s_tuser,   // cmd
  input  wire logic        clearing,
  output logic             op_valid,
  input  wire logic        op_ready,
  output op_t              op
);

  // Start of each 8 KB RAM bank, already folded into the RAM depth.
  localparam logic [RAM_IDX_W-1:0] BANK_BASE1 = RAM_IDX_W'((RAM_BANK_SIZE * 1) % RAM_DEPTH);
  localparam logic [RAM_IDX_W-1:0] BANK_BASE2 = RAM_IDX_W'((RAM_BANK_SIZE * 2) % RAM_DEPTH);
  localparam logic [RAM_IDX_W-1:0] BANK_BASE3 = RAM_IDX_W'((RAM_BANK_SIZE * 3) % RAM_DEPTH);

  logic [6:0]  rom_bank;
  logic [6:0]  rom_bank_next;
  logic [1:0]  ram_bank;
  logic [1:0]  ram_bank_next;
  logic        banked_mode;
  logic        banked_mode_next;

  logic [15:0] bus_address;
  logic [7:0]  write_data;
  logic        fire;
  logic        in_rom;
  logic        in_ram;
  logic [4:0]  low_bits;
  logic [RAM_IDX_W-1:0] bank_base;
  logic [RAM_IDX_W:0]   ram_sum;

  assign bus_address = s_tdata[15:0];
  assign write_data  = s_tdata[23:16];
  assign s_tready    = op_ready && !clearing;
  assign op_valid    = s_tvalid && !clearing;
  assign fire        = s_tvalid && s_tready;
  assign in_rom      = !bus_address[15];
  assign in_ram      = bus_address[15:13] == RAM_WINDOW_TAG;
  assign low_bits    = (write_data[4:0] == 5'd0) ? 5'd1 : write_data[4:0];

  always_comb begin
    case (ram_bank)
      2'd1:    bank_base = BANK_BASE1;
      2'd2:    bank_base = BANK_BASE2;
      2'd3:    bank_base = BANK_BASE3;
      default: bank_base = '0;
    endcase
  end

  // Both terms are below the RAM depth when it holds at least one bank, so one subtract brings the sum back.
  assign ram_sum = {1'b0, bank_base} + (RAM_IDX_W + 1)'(bus_address[12:0]);

  always_comb begin
    op.write_data  = write_data;
    op.rom_address = '0;
    op.ram_index   = (ram_sum >= (RAM_IDX_W + 1)'(RAM_DEPTH))
                     ? RAM_IDX_W'(ram_sum - (RAM_IDX_W + 1)'(RAM_DEPTH))
                     : RAM_IDX_W'(ram_sum);
    op.kind        = OP_ILLEGAL;
    if (s_tuser == CMD_READ) begin
      if (in_rom && !bus_address[14]) begin
        op.kind        = OP_ROM_READ;
        op.rom_address = ROM_ADDR_W'(bus_address);
      end else if (in_rom) begin
        op.kind        = OP_ROM_READ;
        op.rom_address = {rom_bank, bus_address[13:0]};
      end else if (in_ram) begin
        op.kind = OP_RAM_READ;
      end
    end else begin
      if (in_rom) begin
        op.kind = OP_REG_WRITE;
      end else if (in_ram) begin
        op.kind = OP_RAM_WRITE;
      end
    end
  end

  always_comb begin
    rom_bank_next    = rom_bank;
    ram_bank_next    = ram_bank;
    banked_mode_next = banked_mode;
    if (fire && s_tuser == CMD_WRITE && in_rom) begin
      case (bus_address[14:13])
        REG_SEL_LOW: begin
          rom_bank_next = {rom_bank[6:5], low_bits};
        end
        REG_SEL_HIGH: begin
          if (banked_mode) begin
            ram_bank_next = write_data[1:0];
          end else begin
            rom_bank_next = {write_data[1:0], rom_bank[4:0]};
          end
        end
        REG_SEL_MODE: begin
          banked_mode_next = write_data[0];
        end
        default: begin
          // The enable register is not kept.
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rom_bank    <= 7'd1;
      ram_bank    <= 2'd0;
      banked_mode <= 1'b0;
    end else begin
      rom_bank    <= rom_bank_next;
      ram_bank    <= ram_bank_next;
      banked_mode <= banked_mode_next;
    end
  end

endmodule
`default_nettype wire

/* rtl/mbc1_queue.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbc1_queue
// Two-entry queue of classified operations between the front and back ends.
// ----------------------------------------------------------------------------
module mbc1_queue import mbc1_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire op_t  in_op,
  output logic      out_valid,
  input  wire logic out_ready,
  output op_t       out_op
);

  op_t        entries [2];
  logic       head;
  logic       tail;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = count != 2'd2;
  assign out_valid = count != 2'd0;
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;
  assign out_op    = entries[head];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= in_op;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= 1'b0;
      tail  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        tail <= !tail;
      end
      if (pop) begin
        head <= !head;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

/* rtl/mbc1_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mbc1_back
// Carries out queued operations on the cartridge RAM and holds the result
// word in an output register. Clears the RAM after reset.
// ----------------------------------------------------------------------------
module mbc1_back import mbc1_pkg::*; #(
  parameter int unsigned RAM_DEPTH = 32768
) (
  input  wire logic        clk,
  input  wire logic        rst,
  output logic             clearing,
  input  wire logic        op_valid,
  output logic             op_ready,
  input  wire op_t         op,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // rom_address[20:0], read_data[28:21], zero
  output logic [1:0]       m_tuser    // outcome
);

  localparam int unsigned AW = $clog2(RAM_DEPTH);

  logic [7:0]            mem [RAM_DEPTH];
  logic [AW-1:0]         clr_idx;
  logic [AW-1:0]         idx;
  logic                  pop;
  logic [7:0]            rd_data;
  logic                  out_is_read;
  outcome_t              out_outcome;
  outcome_t              outcome_next;
  logic [ROM_ADDR_W-1:0] out_rom_addr;

  assign idx      = op.ram_index[AW-1:0];
  assign op_ready = !m_tvalid || m_tready;
  assign pop      = op_valid && op_ready;

  always_comb begin
    case (op.kind)
      OP_ROM_READ:  outcome_next = OUT_ROM_READ;
      OP_RAM_READ:  outcome_next = OUT_RAM_READ;
      OP_RAM_WRITE: outcome_next = OUT_WRITE;
      OP_REG_WRITE: outcome_next = OUT_WRITE;
      default:      outcome_next = OUT_ILLEGAL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_idx] <= 8'd0;
    end else if (pop && op.kind == OP_RAM_WRITE) begin
      mem[idx] <= op.write_data;
    end
    if (pop) begin
      rd_data <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_idx  <= '0;
    end else if (clearing) begin
      clr_idx <= clr_idx + AW'(1);
      if (clr_idx == AW'(RAM_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (op_ready) begin
      m_tvalid <= op_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_outcome  <= outcome_next;
      out_is_read  <= op.kind == OP_RAM_READ;
      out_rom_addr <= (op.kind == OP_ROM_READ) ? op.rom_address : '0;
    end
  end

  assign m_tuser = out_outcome;
  assign m_tdata = {3'd0, (out_is_read ? rd_data : 8'd0), out_rom_addr};

`ifndef ASSERT_OFF
  // The front end holds input off until the RAM is clean.
  assert property (@(posedge clk) disable iff (rst) clearing |-> !op_valid)
    else $error("operation queued during RAM clear");

  assert property (@(posedge clk) disable iff (rst) !clearing |=> !clearing)
    else $error("RAM clear restarted without reset");

  assert property (@(posedge clk) disable iff (rst)
      m_tvalid && m_tuser != OUT_ROM_READ |-> m_tdata[ROM_ADDR_W-1:0] == '0)
    else $error("ROM address set on a result that is not a ROM read");

  assert property (@(posedge clk) disable iff (rst)
      m_tvalid && m_tuser != OUT_RAM_READ |-> m_tdata[28:21] == 8'd0)
    else $error("read data set on a result that is not a RAM read");
`endif

endmodule
`default_nettype wire

/* sim/mbc1_bank_mapper_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbc1_bank_mapper_checker
// Watches both streams of the bank controller, keeps its own copy of the bank
// registers and the cartridge RAM, predicts the result word of every accepted
// access, and compares each result word with the oldest prediction.
// ----------------------------------------------------------------------------
module mbc1_bank_mapper_checker import mbc1_pkg::*; #(
  parameter int unsigned RAM_DEPTH = 32768
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,   // bus_address[15:0], write_data[23:16]
  input  logic        s_tuser,   // cmd
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,   // rom_address[20:0], read_data[28:21], zero
  input  logic [1:0]  m_tuser,   // outcome
  output int unsigned mismatch_count,
  output int unsigned mappings_outstanding
);

  typedef struct {
    outcome_t              outcome;
    logic [ROM_ADDR_W-1:0] rom_address;
    logic [7:0]            read_data;
  } mapping_t;

  logic [6:0] rom_bank_sel;
  logic [1:0] ram_bank_sel;
  logic       ram_mode;
  logic [7:0] ram_image [RAM_DEPTH];
  mapping_t   predicted_mappings [$];

  initial begin
    mismatch_count       = 0;
    mappings_outstanding = 0;
  end

  task automatic report_mismatch(input string field, input longint unsigned want,
                                 input longint unsigned got);
    // Keep the log short if the block is badly broken; the count still goes on.
    if (mismatch_count < 40)
      $display("%0t ns: mismatch on %s, expected 0x%0h, got 0x%0h",
               $time, field, want, got);
    mismatch_count++;
  endtask

  // Works out the result word of one access and applies its side effects.
  function automatic mapping_t map_access(input logic cmd, input logic [15:0] addr,
                                          input logic [7:0] data);
    mapping_t    res;
    int unsigned ram_idx;
    logic        in_ram_window;
    logic [4:0]  low_bits;
    res.outcome     = OUT_ILLEGAL;
    res.rom_address = '0;
    res.read_data   = '0;
    ram_idx = (int'(ram_bank_sel) * RAM_BANK_SIZE + int'(addr[12:0])) % RAM_DEPTH;
    in_ram_window = (addr[15:13] == RAM_WINDOW_TAG);
    if (cmd == CMD_READ) begin
      if (!addr[15]) begin
        res.outcome     = OUT_ROM_READ;
        res.rom_address = addr[14] ? {rom_bank_sel, addr[13:0]} : {5'd0, addr};
      end else if (in_ram_window) begin
        res.outcome   = OUT_RAM_READ;
        res.read_data = ram_image[ram_idx];
      end
    end else begin
      if (!addr[15]) begin
        res.outcome = OUT_WRITE;
        case (addr[14:13])
          REG_SEL_ENABLE: ; // The enable flag is not kept.
          REG_SEL_LOW: begin
            low_bits = (data[4:0] == 5'd0) ? 5'd1 : data[4:0];
            rom_bank_sel = {rom_bank_sel[6:5], low_bits};
          end
          REG_SEL_HIGH: begin
            if (ram_mode) ram_bank_sel = data[1:0];
            else rom_bank_sel[6:5] = data[1:0];
          end
          REG_SEL_MODE: ram_mode = data[0];
        endcase
      end else if (in_ram_window) begin
        res.outcome        = OUT_WRITE;
        ram_image[ram_idx] = data;
      end
    end
    return res;
  endfunction

  task automatic check_result();
    mapping_t want;
    if (predicted_mappings.size() == 0) begin
      report_mismatch("result word with nothing expected", 0, {m_tuser, m_tdata});
      return;
    end
    want = predicted_mappings.pop_front();
    if (m_tuser != want.outcome)
      report_mismatch("outcome", want.outcome, m_tuser);
    if (m_tdata[20:0] != want.rom_address)
      report_mismatch("rom_address", want.rom_address, m_tdata[20:0]);
    if (m_tdata[28:21] != want.read_data)
      report_mismatch("read_data", want.read_data, m_tdata[28:21]);
    if (m_tdata[31:29] != 3'd0)
      report_mismatch("tdata padding", 0, m_tdata[31:29]);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rom_bank_sel = 7'd1;
      ram_bank_sel = 2'd0;
      ram_mode     = 1'b0;
      for (int i = 0; i < RAM_DEPTH; i++) ram_image[i] = 8'd0;
      predicted_mappings.delete();
    end else begin
      if (m_tvalid && m_tready) check_result();
      if (s_tvalid && s_tready)
        predicted_mappings.push_back(map_access(s_tuser, s_tdata[15:0], s_tdata[23:16]));
    end
    mappings_outstanding = predicted_mappings.size();
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives bus accesses into the bank controller: a directed run over the
// address map edges and register corner cases, then weighted random accesses,
// with random gaps on both streams and one long output stall. The checker
// predicts and compares; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb;
  import mbc1_pkg::*;

  localparam int unsigned RAM_DEPTH    = 32768;
  localparam int unsigned RANDOM_WORDS = 1600;
  // The RAM clear after reset is the longest quiet stretch of a correct run.
  localparam int unsigned STALL_LIMIT  = 4 * RAM_DEPTH;
  localparam int unsigned HOLD_AT      = 150;
  localparam int unsigned HOLD_CYCLES  = 400;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;

  int unsigned mismatch_count;
  int unsigned mappings_outstanding;
  int unsigned words_sent;
  int unsigned quiet_cycles;

  mbc1_bank_mapper_core #(.RAM_DEPTH(RAM_DEPTH)) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  mbc1_bank_mapper_checker #(.RAM_DEPTH(RAM_DEPTH)) u_checker (
    .clk                  (clk),
    .rst                  (rst),
    .s_tvalid             (s_tvalid),
    .s_tready             (s_tready),
    .s_tdata              (s_tdata),
    .s_tuser              (s_tuser),
    .m_tvalid             (m_tvalid),
    .m_tready             (m_tready),
    .m_tdata              (m_tdata),
    .m_tuser              (m_tuser),
    .mismatch_count       (mismatch_count),
    .mappings_outstanding (mappings_outstanding)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Stretches without any gap alternate with stretches of random gaps.
  function automatic int idle_draw(input int unsigned n, input int unsigned phase);
    if (((n + phase) % 160) < 40) return 0;
    return $urandom_range(15);
  endfunction

  function automatic logic [15:0] ram_window_address();
    logic [12:0] offset;
    // Mostly a narrow range so that reads find bytes written earlier.
    if ($urandom_range(3) == 0) offset = 13'($urandom_range(8191));
    else offset = 13'($urandom_range(63));
    return {RAM_WINDOW_TAG, offset};
  endfunction

  task automatic drive_access(input logic cmd, input logic [15:0] addr,
                              input logic [7:0] data);
    int gap;
    gap = idle_draw(words_sent, 0);
    @(negedge clk);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {data, addr};
    s_tuser  <= cmd;
    do @(posedge clk); while (!s_tready);
    words_sent++;
  endtask

  // Result side: random back-pressure, and one long hold-off so that the
  // block fills up and stalls its input.
  initial begin
    int          gap;
    int unsigned taken;
    m_tready = 1'b0;
    taken    = 0;
    forever begin
      if (taken == HOLD_AT) gap = HOLD_CYCLES;
      else gap = idle_draw(taken, 80);
      @(negedge clk);
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      taken++;
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("mbc1_bank_mapper_core test failed");
        $finish;
      end
    end
  end

  initial begin
    logic        cmd;
    logic [15:0] addr;
    logic [7:0]  data;
    int unsigned pick;
    rst          = 1'b1;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    s_tuser      = CMD_READ;
    words_sent   = 0;
    quiet_cycles = 0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Edges of the ROM windows with the reset bank.
    drive_access(CMD_READ,  16'h0000, 8'h00);
    drive_access(CMD_READ,  16'h3FFF, 8'hFF);
    drive_access(CMD_READ,  16'h4000, 8'h00);
    drive_access(CMD_READ,  16'h7FFF, 8'h00);
    // A zero low bank turns into one; then the largest bank number.
    drive_access(CMD_WRITE, 16'h2000, 8'h00);
    drive_access(CMD_WRITE, 16'h3FFF, 8'hFF);
    drive_access(CMD_WRITE, 16'h4000, 8'h03);
    drive_access(CMD_READ,  16'h7ABC, 8'h00);
    drive_access(CMD_WRITE, 16'h0000, 8'h0A);
    drive_access(CMD_WRITE, 16'h1FFF, 8'hFF);
    // Banked RAM mode, RAM bank two, and both ends of the RAM window.
    drive_access(CMD_WRITE, 16'h6000, 8'h01);
    drive_access(CMD_WRITE, 16'h5FFF, 8'h02);
    drive_access(CMD_WRITE, 16'hA000, 8'hAA);
    drive_access(CMD_READ,  16'hA000, 8'h00);
    drive_access(CMD_WRITE, 16'hBFFF, 8'h55);
    drive_access(CMD_READ,  16'hBFFF, 8'h00);
    // Back to ROM mode: the RAM bank keeps its value.
    drive_access(CMD_WRITE, 16'h7FFF, 8'hFE);
    drive_access(CMD_READ,  16'hA000, 8'h00);
    drive_access(CMD_WRITE, 16'h4000, 8'h00);
    // Addresses outside every window, then a RAM read and a banked ROM read.
    drive_access(CMD_READ,  16'h8000, 8'h00);
    drive_access(CMD_WRITE, 16'h9FFF, 8'h11);
    drive_access(CMD_READ,  16'hC000, 8'h00);
    drive_access(CMD_WRITE, 16'hFFFF, 8'hFF);
    drive_access(CMD_READ,  16'hB123, 8'h00);
    drive_access(CMD_READ,  16'h5555, 8'h00);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      pick = $urandom_range(99);
      data = 8'($urandom_range(255));
      if (pick < 30) begin
        cmd  = CMD_READ;
        addr = 16'($urandom_range(16'h7FFF));
      end else if (pick < 55) begin
        cmd  = CMD_READ;
        addr = ram_window_address();
      end else if (pick < 75) begin
        cmd  = CMD_WRITE;
        addr = ram_window_address();
      end else if (pick < 90) begin
        cmd  = CMD_WRITE;
        addr = 16'($urandom_range(16'h7FFF));
      end else begin
        cmd  = ($urandom_range(1) == 0) ? CMD_READ : CMD_WRITE;
        addr = 16'($urandom_range(16'hFFFF));
      end
      drive_access(cmd, addr, data);
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (mappings_outstanding != 0) @(negedge clk);
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("mbc1_bank_mapper_core test passed");
    end else begin
      $display("mbc1_bank_mapper_core test failed");
    end
    $finish;
  end

endmodule
